// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top level of the texel format packer
// no dependencies; the checks drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication under a synchronous active-low reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication under a synchronous active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/atfp_pkg.sv =====
// constants, codes and helper functions of the texel format packer
// no dependencies; used by the channel interfaces and the top level
package atfp_pkg;

    localparam int unsigned TexelW   = 32;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned ChanW    = 8;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CntW     = 3;

    // pixel modes
    localparam logic [1:0] PM_CONVERT = 2'd0;
    localparam logic [1:0] PM_COPY32  = 2'd1;
    localparam logic [1:0] PM_COPY16  = 2'd2;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_PIXEL_MODE     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CHANNEL_WIDTHS = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RED_SHIFT      = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_GREEN_SHIFT    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_BLUE_SHIFT     = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_ALPHA_SHIFT    = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_BITS_PER_PIXEL = 3'd6;

    // reset values
    localparam logic [1:0]  RST_PIXEL_MODE     = PM_CONVERT;
    localparam logic [15:0] RST_CHANNEL_WIDTHS = 16'h5555;
    localparam logic [4:0]  RST_RED_SHIFT      = 5'd11;
    localparam logic [4:0]  RST_GREEN_SHIFT    = 5'd5;
    localparam logic [4:0]  RST_BLUE_SHIFT     = 5'd0;
    localparam logic [4:0]  RST_ALPHA_SHIFT    = 5'd15;
    localparam logic [5:0]  RST_BITS_PER_PIXEL = 6'd16;

    localparam logic [CntW-1:0] MaxBytes = 3'd4;

    // keep the top bits of a channel; widths of eight or more keep it whole
    function automatic logic [ChanW-1:0] f_cut(logic [ChanW-1:0] chan, logic [3:0] width);
        logic [3:0] sh;
        sh = 4'd8 - width;
        if (width >= 4'd8) begin
            return chan;
        end
        return chan >> sh;
    endfunction

    // move a cut channel to its bit position, dropping bits past bit 31
    function automatic logic [TexelW-1:0] f_place(logic [ChanW-1:0] val, logic [4:0] pos);
        logic [TexelW-1:0] ext;
        ext = {{(TexelW-ChanW){1'b0}}, val};
        return ext << pos;
    endfunction

endpackage

// ===== hw/rtl/atfp_texel_if.sv =====
// texel input channel: valid, ready and the source pixel word
// depends on atfp_pkg
interface atfp_texel_if import atfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TexelW-1:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

// ===== hw/rtl/atfp_byte_if.sv =====
// byte output channel: valid, ready, one destination byte and its last mark
// depends on atfp_pkg
interface atfp_byte_if import atfp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] out_byte;
    logic             last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/argb_texel_format_packer.sv =====
// top level of the texel format packer: pipeline, byte serializer, config registers
// depends on atfp_pkg, atfp_texel_if, atfp_byte_if and assert_macros.svh
`include "assert_macros.svh"

// Converts one 32-bit ARGB texel (alpha 31:24, red 23:16, green 15:8, blue 7:0)
// into a destination pixel sent as bytes, least significant first, with the
// last byte marked. Convert mode cuts each channel to its configured width,
// places it at its configured bit position and sends ceil(bits_per_pixel/8)
// bytes (at most four); the copy modes send the texel as four or two bytes.
// Mode three and convert with bits_per_pixel zero drop the texel without output. A texel
// passes a cut stage, a place/merge stage and a serializer, then the output
// register. The serializer sends one byte per cycle while o_byte.ready allows,
// and it takes the next texel as it sends the last byte of the current one.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must write it only while the block is idle, which the block does not
// enforce. Indexes beyond the register list are ignored.
module argb_texel_format_packer import atfp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    atfp_texel_if.sink          i_texel,
    atfp_byte_if.source         o_byte,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    // configuration registers
    logic [1:0]  r_pixel_mode;
    logic [15:0] r_channel_widths;
    logic [4:0]  r_red_shift;
    logic [4:0]  r_green_shift;
    logic [4:0]  r_blue_shift;
    logic [4:0]  r_alpha_shift;
    logic [5:0]  r_bits_per_pixel;

    // stage 1: cut channels, raw texel, byte count
    logic              r_s1_valid;
    logic [TexelW-1:0] r_s1_texel;
    logic [ChanW-1:0]  r_s1_chan [4];
    logic              r_s1_copy;
    logic [CntW-1:0]   r_s1_cnt;

    // stage 2: merged destination word
    logic              r_s2_valid;
    logic [TexelW-1:0] r_s2_word;
    logic [CntW-1:0]   r_s2_cnt;

    // stage 3: serializer, count of bytes still to send (zero means empty)
    logic [TexelW-1:0] r_s3_word;
    logic [CntW-1:0]   r_s3_cnt;

    // output register
    logic             r_out_valid;
    logic [ByteW-1:0] r_out_byte;
    logic             r_out_last;

    logic            out_load;
    logic            s3_ready;
    logic            s2_ready;
    logic            s1_ready;
    logic            in_fire;
    logic [CntW-1:0] n_cnt;
    logic [6:0]      bpp_round;
    logic [3:0]      bpp_bytes;
    logic [TexelW-1:0] n_word;

    // handshake chain, each stage moves when the one after it has room
    assign out_load = !r_out_valid || o_byte.ready;
    assign s3_ready = (r_s3_cnt == '0) || ((r_s3_cnt == CntW'(1)) && out_load);
    assign s2_ready = !r_s2_valid || s3_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign in_fire  = i_texel.valid && s1_ready;

    assign i_texel.ready   = s1_ready;
    assign o_byte.valid    = r_out_valid;
    assign o_byte.out_byte = r_out_byte;
    assign o_byte.last_byte = r_out_last;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode     <= RST_PIXEL_MODE;
            r_channel_widths <= RST_CHANNEL_WIDTHS;
            r_red_shift      <= RST_RED_SHIFT;
            r_green_shift    <= RST_GREEN_SHIFT;
            r_blue_shift     <= RST_BLUE_SHIFT;
            r_alpha_shift    <= RST_ALPHA_SHIFT;
            r_bits_per_pixel <= RST_BITS_PER_PIXEL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PIXEL_MODE:     r_pixel_mode     <= i_cfg_data[1:0];
                REG_CHANNEL_WIDTHS: r_channel_widths <= i_cfg_data[15:0];
                REG_RED_SHIFT:      r_red_shift      <= i_cfg_data[4:0];
                REG_GREEN_SHIFT:    r_green_shift    <= i_cfg_data[4:0];
                REG_BLUE_SHIFT:     r_blue_shift     <= i_cfg_data[4:0];
                REG_ALPHA_SHIFT:    r_alpha_shift    <= i_cfg_data[4:0];
                REG_BITS_PER_PIXEL: r_bits_per_pixel <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // byte count per mode; convert rounds bits up to bytes and caps at four
    assign bpp_round = {1'b0, r_bits_per_pixel} + 7'd7;
    assign bpp_bytes = bpp_round[6:3];

    always_comb begin
        case (r_pixel_mode)
            PM_CONVERT: begin
                n_cnt = (bpp_bytes > 4'd4) ? MaxBytes : bpp_bytes[CntW-1:0];
            end
            PM_COPY32: n_cnt = MaxBytes;
            PM_COPY16: n_cnt = CntW'(2);
            default:   n_cnt = '0;
        endcase
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_texel.valid;
        end
    end

    // stage 1 payload: channel cut, red/green/blue/alpha in lanes 0..3
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_texel   <= i_texel.pixel_word;
            r_s1_chan[0] <= f_cut(i_texel.pixel_word[23:16], r_channel_widths[3:0]);
            r_s1_chan[1] <= f_cut(i_texel.pixel_word[15:8],  r_channel_widths[7:4]);
            r_s1_chan[2] <= f_cut(i_texel.pixel_word[7:0],   r_channel_widths[11:8]);
            r_s1_chan[3] <= f_cut(i_texel.pixel_word[31:24], r_channel_widths[15:12]);
            r_s1_copy    <= (r_pixel_mode != PM_CONVERT);
            r_s1_cnt     <= n_cnt;
        end
    end

    // stage 2: place the fields and merge them, or pass the texel in copy modes
    always_comb begin
        if (r_s1_copy) begin
            n_word = r_s1_texel;
        end else begin
            n_word = f_place(r_s1_chan[0], r_red_shift)
                   | f_place(r_s1_chan[1], r_green_shift)
                   | f_place(r_s1_chan[2], r_blue_shift)
                   | f_place(r_s1_chan[3], r_alpha_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_word <= n_word;
            r_s2_cnt  <= r_s1_cnt;
        end
    end

    // stage 3: serializer, a count of zero drops the transaction here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_cnt <= '0;
        end else if (s3_ready) begin
            r_s3_cnt <= r_s2_valid ? r_s2_cnt : '0;
        end else if (out_load) begin
            r_s3_cnt <= r_s3_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && r_s2_valid) begin
            r_s3_word <= r_s2_word;
        end else if (out_load && (r_s3_cnt != '0)) begin
            r_s3_word <= r_s3_word >> ByteW;
        end
    end

    // output register, parts the serializer from the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= (r_s3_cnt != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && (r_s3_cnt != '0)) begin
            r_out_byte <= r_s3_word[ByteW-1:0];
            r_out_last <= (r_s3_cnt == CntW'(1));
        end
    end

    // bytes of one pixel leave back to back
    `ASSERT_NEXT(a_burst_contiguous, i_clk, i_rst_n,
        o_byte.valid && o_byte.ready && !o_byte.last_byte, o_byte.valid)
    // a shown byte that is not the last has its followers waiting in the serializer
    `ASSERT_IMPLIES(a_rest_pending, i_clk, i_rst_n,
        r_out_valid && !r_out_last, r_s3_cnt != '0)
    // never more than four bytes per pixel
    `ASSERT_IMPLIES(a_cnt_range, i_clk, i_rst_n, r_s2_valid, r_s2_cnt <= MaxBytes)

endmodule
